/* sv/pcsp_pkg.sv */
// shared types and constants of the panel command sequence player
`default_nettype none
package pcsp_pkg;

    localparam int DEF_TABLE_DEPTH = 64;

    // input opcodes
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [7:0]  PREFIX_INDEX   = 8'h70;
    localparam logic [7:0]  PREFIX_DATA    = 8'h72;
    localparam logic [15:0] CLASS_MASK     = 16'hFF00;
    localparam logic [15:0] CODE_SLEEP     = 16'h1000;
    localparam logic [15:0] CODE_END       = 16'h2000;
    localparam logic [7:0]  DATA_WORD_CODE = 8'hFF;

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] value;
    } t_entry;

    // what one executed item produces
    typedef struct packed {
        logic [15:0] word0;
        logic        wvalid0;
        logic [15:0] word1;
        logic        two;
        logic        busy;
        logic        done;
    } t_step_res;

    // one result as held in the output slots
    typedef struct packed {
        logic [15:0] word;
        logic        word_valid;
        logic        busy;
        logic        done;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

/* sv/pcsp_table.sv */
// command table memory with registered read and write-to-read bypass
`default_nettype none
module pcsp_table #(
    parameter int DEPTH = pcsp_pkg::DEF_TABLE_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire pcsp_pkg::t_entry i_wr_data,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output pcsp_pkg::t_entry     o_rd_data
);

    pcsp_pkg::t_entry r_mem [DEPTH];
    pcsp_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // a write in the same cycle to the read address is returned directly
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* sv/pcsp_core.sv */
// run state (pointer, delay, running) and single-step execution of one item
`default_nettype none
module pcsp_core #(
    parameter int DEPTH = pcsp_pkg::DEF_TABLE_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [5:0]        i_start_index,
    input  wire pcsp_pkg::t_entry  i_entry,
    output logic [AW-1:0]          o_next_ptr,
    output pcsp_pkg::t_step_res    o_res
);

    logic [AW-1:0] r_ptr;
    logic [15:0]   r_delay;
    logic          r_running;
    logic [AW-1:0] n_ptr;
    logic [15:0]   n_delay;
    logic          n_running;
    logic          at_end;
    logic [15:0]   code_class;

    assign at_end     = (r_ptr == AW'(DEPTH - 1));
    assign code_class = i_entry.code & pcsp_pkg::CLASS_MASK;

    always_comb begin
        n_ptr     = r_ptr;
        n_delay   = r_delay;
        n_running = r_running;
        o_res     = '0;
        if (i_fire) begin
            case (i_opcode)
                pcsp_pkg::OP_START: begin
                    if (32'(i_start_index) < 32'(DEPTH)) begin
                        n_ptr     = AW'(i_start_index);
                        n_delay   = '0;
                        n_running = 1'b1;
                    end
                end
                pcsp_pkg::OP_TICK: begin
                    if (r_running) begin
                        if (r_delay != '0) begin
                            n_delay = r_delay - 16'd1;
                        end else if (code_class == pcsp_pkg::CODE_END) begin
                            n_running  = 1'b0;
                            o_res.done = 1'b1;
                        end else begin
                            if (code_class == pcsp_pkg::CODE_SLEEP) begin
                                // a sleep in the last entry is dropped
                                if (!at_end) begin
                                    n_delay = i_entry.value;
                                end
                            end else if (i_entry.code[7:0] == pcsp_pkg::DATA_WORD_CODE) begin
                                o_res.word0   = {pcsp_pkg::PREFIX_DATA, i_entry.value[7:0]};
                                o_res.wvalid0 = 1'b1;
                            end else begin
                                o_res.word0   = {pcsp_pkg::PREFIX_INDEX, i_entry.code[7:0]};
                                o_res.wvalid0 = 1'b1;
                                o_res.word1   = {pcsp_pkg::PREFIX_DATA, i_entry.value[7:0]};
                                o_res.two     = 1'b1;
                            end
                            if (at_end) begin
                                n_running  = 1'b0;
                                o_res.done = 1'b1;
                                n_ptr      = '0;
                            end else begin
                                n_ptr = r_ptr + AW'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.busy = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_delay   <= '0;
            r_running <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_delay   <= n_delay;
            r_running <= n_running;
        end
    end

    // state as the next accepted item will see it
    assign o_next_ptr = n_ptr;

endmodule
`default_nettype wire

/* sv/panel_command_sequence_player.sv */
// panel command sequence player: top level with input register and output slots
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | opcode, entry_index/code/value, start_index
//  out     | from block| o_out_valid / i_out_stall  | spi_word, word_valid, busy, done, last
//
// an item is registered on transfer, the table entry at the run pointer is read in the
// same edge, and the item executes into a two-slot output register once the slots have
// room. an item may enter every cycle while o_in_stall is low; a register entry yields
// two results, one transfer each, so the next item waits until the second is taken.
// reset is synchronous and clears the pointer, delay, run flag and valids; the table
// holds no defined contents until written. a stalled output holds both slots.
`default_nettype none
module panel_command_sequence_player #(
    parameter int TABLE_DEPTH = pcsp_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [5:0]  i_entry_index,
    input  wire logic [15:0] i_entry_code,
    input  wire logic [15:0] i_entry_value,
    input  wire logic [5:0]  i_start_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_spi_word,
    output logic             o_word_valid,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic             o_last
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [5:0]  r_in_idx;
    logic [15:0] r_in_code;
    logic [15:0] r_in_value;
    logic [5:0]  r_in_sidx;

    pcsp_pkg::t_result   r_slot0, r_slot1, n_slot0, n_slot1;
    logic [1:0]          r_cnt, n_cnt;

    pcsp_pkg::t_entry    rd_entry;
    pcsp_pkg::t_entry    wr_entry;
    pcsp_pkg::t_step_res step_res;
    logic [AW-1:0]       next_ptr;
    logic                in_xfer, out_xfer, fire, wr_en;

    assign out_xfer   = (r_cnt != 2'd0) && !i_out_stall;
    // execute only when the slots are empty after this cycle's transfer
    assign fire       = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_xfer));
    assign o_in_stall = r_in_valid && !fire;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign wr_en    = fire && (r_in_op == pcsp_pkg::OP_STORE)
                      && (32'(r_in_idx) < 32'(TABLE_DEPTH));
    assign wr_entry = '{code: r_in_code, value: r_in_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op    <= i_opcode;
            r_in_idx   <= i_entry_index;
            r_in_code  <= i_entry_code;
            r_in_value <= i_entry_value;
            r_in_sidx  <= i_start_index;
        end
    end

    pcsp_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(AW'(r_in_idx)),
        .i_wr_data(wr_entry),
        .i_rd_en  (in_xfer),
        .i_rd_addr(next_ptr),
        .o_rd_data(rd_entry)
    );

    pcsp_core #(
        .DEPTH(TABLE_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_opcode     (r_in_op),
        .i_start_index(r_in_sidx),
        .i_entry      (rd_entry),
        .o_next_ptr   (next_ptr),
        .o_res        (step_res)
    );

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;
        if (fire) begin
            n_slot0 = '{word: step_res.word0, word_valid: step_res.wvalid0,
                        busy: step_res.busy, done: step_res.done, last: !step_res.two};
            n_slot1 = '{word: step_res.word1, word_valid: 1'b1,
                        busy: step_res.busy, done: step_res.done, last: 1'b1};
            n_cnt   = step_res.two ? 2'd2 : 2'd1;
        end else if (out_xfer) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_spi_word   = r_slot0.word;
    assign o_word_valid = r_slot0.word_valid;
    assign o_busy_res   = r_slot0.busy;
    assign o_done_res   = r_slot0.done;
    assign o_last       = r_slot0.last;

endmodule
`default_nettype wire

/* sv/pcsp_chk.sv */
// port-level checker for the panel command sequence player and its bind
`default_nettype none
module pcsp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] i_spi_word,
    input wire logic        i_word_valid,
    input wire logic        i_busy_res,
    input wire logic        i_done_res,
    input wire logic        i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_spi_word) && $stable(i_last))
        else $error("stalled output changed");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_word_valid |-> i_spi_word == 16'h0000)
        else $error("word without valid flag is not zero");

    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_word_valid |->
            (i_spi_word[15:8] == pcsp_pkg::PREFIX_INDEX)
            || (i_spi_word[15:8] == pcsp_pkg::PREFIX_DATA))
        else $error("bad word prefix");

    // an index word is always followed by its data word
    a_index_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_word_valid && (i_spi_word[15:8] == pcsp_pkg::PREFIX_INDEX)
            |-> !i_last)
        else $error("index word marked last");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> !i_busy_res)
        else $error("done while busy");

endmodule

bind panel_command_sequence_player pcsp_chk u_pcsp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_spi_word  (o_spi_word),
    .i_word_valid(o_word_valid),
    .i_busy_res  (o_busy_res),
    .i_done_res  (o_done_res),
    .i_last      (o_last)
);
`default_nettype wire

/* tb/pcsp_checker.sv */
`timescale 1ns / 100ps
// result checker for the panel command sequence player: predicts and compares serial words
module pcsp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [5:0]  i_entry_index,
    input  wire logic [15:0] i_entry_code,
    input  wire logic [15:0] i_entry_value,
    input  wire logic [5:0]  i_start_index,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_spi_word,
    input  wire logic        i_word_valid,
    input  wire logic        i_busy_res,
    input  wire logic        i_done_res,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending
);

    localparam int DEPTH = pcsp_pkg::DEF_TABLE_DEPTH;
    localparam int REPORT_LIMIT = 10;

    logic [15:0]       cmd_code [DEPTH];
    logic [15:0]       cmd_value [DEPTH];
    logic [5:0]        play_ptr = '0;
    logic [15:0]       sleep_left = '0;
    logic              playing = 1'b0;
    pcsp_pkg::t_result words_due [$];
    int                mismatches = 0;

    task automatic note_mismatch(input string what, input pcsp_pkg::t_result want,
                                 input pcsp_pkg::t_result got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t %s: expected word %h wv %0b busy %0b done %0b last %0b", $realtime,
                     what, want.word, want.word_valid, want.busy, want.done, want.last);
            $display("    got word %h wv %0b busy %0b done %0b last %0b",
                     got.word, got.word_valid, got.busy, got.done, got.last);
        end
    endtask

    // applies one input item to the shadow player and queues the words it should emit
    task automatic play_item(input logic [1:0] op, input logic [5:0] eidx,
                             input logic [15:0] ecode, input logic [15:0] evalue,
                             input logic [5:0] sidx);
        pcsp_pkg::t_result res [2];
        int                n;
        logic              ended;
        logic              at_top;
        logic [15:0]       c;
        logic [15:0]       v;
        n = 1;
        ended = 1'b0;
        res[0] = '0;
        res[1] = '0;
        case (op)
            pcsp_pkg::OP_STORE: begin
                if (int'(eidx) < DEPTH) begin
                    cmd_code[eidx] = ecode;
                    cmd_value[eidx] = evalue;
                end
            end
            pcsp_pkg::OP_START: begin
                if (int'(sidx) < DEPTH) begin
                    play_ptr = sidx;
                    sleep_left = '0;
                    playing = 1'b1;
                end
            end
            pcsp_pkg::OP_TICK: begin
                if (playing) begin
                    if (sleep_left != 16'd0) begin
                        sleep_left = sleep_left - 16'd1;
                    end else begin
                        c = cmd_code[play_ptr];
                        v = cmd_value[play_ptr];
                        at_top = (int'(play_ptr) == DEPTH - 1);
                        if ((c & pcsp_pkg::CLASS_MASK) == pcsp_pkg::CODE_END) begin
                            playing = 1'b0;
                            ended = 1'b1;
                        end else begin
                            if ((c & pcsp_pkg::CLASS_MASK) == pcsp_pkg::CODE_SLEEP) begin
                                // the last table entry never arms a delay
                                if (!at_top) begin
                                    sleep_left = v;
                                end
                            end else if (c[7:0] == pcsp_pkg::DATA_WORD_CODE) begin
                                res[0].word = {pcsp_pkg::PREFIX_DATA, v[7:0]};
                                res[0].word_valid = 1'b1;
                            end else begin
                                res[0].word = {pcsp_pkg::PREFIX_INDEX, c[7:0]};
                                res[0].word_valid = 1'b1;
                                res[1].word = {pcsp_pkg::PREFIX_DATA, v[7:0]};
                                res[1].word_valid = 1'b1;
                                n = 2;
                            end
                            if (at_top) begin
                                playing = 1'b0;
                                ended = 1'b1;
                                play_ptr = '0;
                            end else begin
                                play_ptr = play_ptr + 6'd1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < n; k++) begin
            res[k].busy = playing;
            res[k].done = ended;
            res[k].last = (k == n - 1);
            words_due.push_back(res[k]);
        end
    endtask

    always @(posedge i_clk) begin
        pcsp_pkg::t_result got;
        pcsp_pkg::t_result want;
        if (!i_rst_n) begin
            words_due.delete();
            play_ptr = '0;
            sleep_left = '0;
            playing = 1'b0;
        end else begin
            // results first: a result never belongs to the item of the same edge
            if (i_out_valid && !i_out_stall) begin
                got.word = i_spi_word;
                got.word_valid = i_word_valid;
                got.busy = i_busy_res;
                got.done = i_done_res;
                got.last = i_last;
                if (words_due.size() == 0) begin
                    note_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = words_due.pop_front();
                    if (got !== want) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                play_item(i_opcode, i_entry_index, i_entry_code, i_entry_value, i_start_index);
            end
        end
        o_pending <= words_due.size();
        o_errors <= mismatches;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// testbench top for the panel command sequence player: clock, reset, stimulus and verdict
module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DEPTH = pcsp_pkg::DEF_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_opcode = OP_UNUSED;
    logic [5:0]  i_entry_index = '0;
    logic [15:0] i_entry_code = '0;
    logic [15:0] i_entry_value = '0;
    logic [5:0]  i_start_index = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_spi_word;
    logic        o_word_valid;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_last;
    int          errors;
    int          pending;

    // table rows written so far; a run may only start where every row above it is written
    bit [DEPTH-1:0] filled = '0;
    int             fill_lo = DEPTH;
    int             sent = 0;
    bit             gaps_on = 1'b1;
    int             idle_cycles = 0;

    panel_command_sequence_player u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_code  (i_entry_code),
        .i_entry_value (i_entry_value),
        .i_start_index (i_start_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_spi_word    (o_spi_word),
        .o_word_valid  (o_word_valid),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_last        (o_last)
    );

    pcsp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_code  (i_entry_code),
        .i_entry_value (i_entry_value),
        .i_start_index (i_start_index),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_spi_word    (o_spi_word),
        .i_word_valid  (o_word_valid),
        .i_busy_res    (o_busy_res),
        .i_done_res    (o_done_res),
        .i_last        (o_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure: stall bursts between quiet stretches
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (r >= 40) begin
                i_out_stall <= 1'b1;
                if (r < 85) begin
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else if (r < 96) begin
                    repeat ($urandom_range(4, 12)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(20, 40)) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else if (r < 90) begin
                repeat ($urandom_range(4, 10)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offers one item and returns at the edge of its transfer
    task automatic send_item(input logic [1:0] op, input logic [5:0] eidx,
                             input logic [15:0] ecode, input logic [15:0] evalue,
                             input logic [5:0] sidx);
        int   gap;
        logic held;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_entry_index <= eidx;
        i_entry_code <= ecode;
        i_entry_value <= evalue;
        i_start_index <= sidx;
        do begin
            @(negedge i_clk);
            held = o_in_stall;
            @(posedge i_clk);
        end while (held);
        if (op == pcsp_pkg::OP_STORE) begin
            filled[eidx] = 1'b1;
            while (fill_lo > 0 && filled[6'(fill_lo - 1)]) fill_lo--;
        end
        if (op != OP_UNUSED) sent++;
    endtask

    task automatic store(input int idx, input logic [15:0] c, input logic [15:0] v);
        send_item(pcsp_pkg::OP_STORE, 6'(idx), c, v, 6'($urandom));
    endtask

    task automatic start_at(input int idx);
        send_item(pcsp_pkg::OP_START, 6'($urandom), 16'($urandom), 16'($urandom), 6'(idx));
    endtask

    task automatic tick();
        send_item(pcsp_pkg::OP_TICK, 6'($urandom), 16'($urandom), 16'($urandom),
                  6'($urandom));
    endtask

    task automatic store_random(input int idx, input bit want_end);
        logic [15:0] c;
        logic [15:0] v;
        int          pick;
        pick = $urandom_range(0, 99);
        v = 16'($urandom);
        if (want_end || pick < 8) begin
            c = pcsp_pkg::CODE_END | 16'($urandom_range(0, 255));
        end else if (pick < 25) begin
            c = pcsp_pkg::CODE_SLEEP | 16'($urandom_range(0, 255));
            // mostly short sleeps, now and then a long one that a restart cuts off
            if ($urandom_range(0, 9) != 0) v = 16'($urandom_range(0, 3));
        end else if (pick < 45) begin
            c = {8'($urandom), pcsp_pkg::DATA_WORD_CODE};
        end else begin
            c = 16'($urandom);
        end
        store(idx, c, v);
    endtask

    task automatic send_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            store_random($urandom_range(0, DEPTH - 1), 1'b0);
        end else if (r < 80) begin
            send_item(OP_UNUSED, 6'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
        end else if (fill_lo < DEPTH) begin
            start_at($urandom_range(fill_lo, DEPTH - 1));
        end else begin
            tick();
        end
    endtask

    // writes a short run of rows that keeps the table filled up to its top, then plays it
    task automatic play_program();
        int base;
        int len;
        int nticks;
        gaps_on = ($urandom_range(0, 3) != 0);
        base = $urandom_range(fill_lo > 6 ? fill_lo - 6 : 0, DEPTH - 1);
        len = (base < fill_lo ? fill_lo - base : 0) + $urandom_range(1, 5);
        if (base + len > DEPTH) len = DEPTH - base;
        for (int k = 0; k < len; k++) begin
            store_random(base + k, (k == len - 1) && ($urandom_range(0, 1) == 1));
        end
        start_at(base);
        nticks = len + $urandom_range(0, 6);
        repeat (nticks) begin
            if ($urandom_range(0, 99) < 15) send_noise();
            tick();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle player: tick and unused opcode do nothing
        tick();
        send_item(OP_UNUSED, 6'h3F, 16'hFFFF, 16'hFFFF, 6'h3F);
        store(56, 16'hFFFF, 16'hFFFF);
        store(57, 16'h0000, 16'h0000);
        store(58, pcsp_pkg::CODE_SLEEP, 16'h0000);
        store(59, pcsp_pkg::CODE_SLEEP | 16'h0005, 16'h0001);
        store(60, 16'h12AB, 16'hA55A);
        store(61, 16'hFFFE, 16'h1234);
        store(62, pcsp_pkg::CODE_END | 16'h00FF, 16'hFFFF);
        store(63, 16'h0042, 16'h00C3);
        // lone data word, register, zero sleep, one-tick sleep, two registers, end marker
        start_at(56);
        repeat (8) tick();
        // register entry in the last row ends the run
        start_at(63);
        tick();
        // sleep in the last row ends the run without a delay
        store(63, pcsp_pkg::CODE_SLEEP | 16'h0007, 16'h0005);
        start_at(63);
        tick();
        tick();
        // restart during a delay clears it
        start_at(59);
        tick();
        start_at(60);
        tick();
        start_at(62);
        tick();

        sent = 0;
        while (sent < RANDOM_ITEMS) play_program();
        i_in_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* panel_command_sequence_player.f */
sv/pcsp_pkg.sv
sv/pcsp_table.sv
sv/pcsp_core.sv
sv/panel_command_sequence_player.sv
sv/pcsp_chk.sv
tb/pcsp_checker.sv
tb/tb_top.sv
